// ===== rtl/core/keyframe_curve_evaluator_defines.svh =====
// Assertion macros for the keyframe curve evaluator.
// Used by keyframe_curve_evaluator.sv in rtl/core; no other dependencies.
`ifndef KEYFRAME_CURVE_EVALUATOR_DEFINES_SVH
`define KEYFRAME_CURVE_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define KCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define KCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define KCE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KCE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/kce_pkg.sv =====
// Shared types, constants and easing function for the keyframe curve evaluator.
// No dependencies.
`default_nettype none
package kce_pkg;
	localparam int DefMaxKeys = 16;

	localparam logic [1:0] ST_EVAL  = 2'd0;
	localparam logic [1:0] ST_STORED = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [2:0] EASE_LINEAR = 3'd0;
	localparam logic [2:0] EASE_STEP   = 3'd1;
	localparam logic [2:0] EASE_IN     = 3'd2;
	localparam logic [2:0] EASE_OUT    = 3'd3;
	localparam logic [2:0] EASE_INOUT  = 3'd4;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef struct packed {
		logic signed [31:0] t;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [2:0]         ease;
	} key_t;

	// base of the squared term for ease modes: returns f or the remaining operand 1-f
	function automatic logic [16:0] ease_base(input logic [16:0] f, input logic [2:0] m);
		logic [16:0] r;
		r = ONE_Q16 - f;
		unique case (m)
			EASE_IN:    ease_base = f;
			EASE_OUT:   ease_base = r;
			EASE_INOUT: ease_base = (f < 17'h08000) ? f : r;
			default:    ease_base = f;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/keyframe_curve_evaluator.sv =====
// Keyframe curve evaluator: an insert or an evaluate command per transaction.
// A key insert shifts the cell chain one cell per cycle from the top; an evaluate
// scans the chain one segment per cycle, then divides, eases and blends.
// A result waiting at the output holds off the next result and, as the FSM waits in S_OUT, the next command.
// Depends on kce_pkg, kce_cell, kce_div, keyframe_curve_evaluator_defines.svh.
`default_nettype none
`include "keyframe_curve_evaluator_defines.svh"
module keyframe_curve_evaluator #(
	parameter int MAX_KEYS = kce_pkg::DefMaxKeys
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic signed [31:0] sample_time,
	input  wire logic signed [31:0] key_x,
	input  wire logic signed [31:0] key_y,
	input  wire logic signed [31:0] key_z,
	input  wire logic [2:0]         ease_mode,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic signed [31:0]      out_z,
	output logic [1:0]              status
);
	import kce_pkg::*;
	localparam int IW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INS  = 4'd1;
	localparam logic [3:0] S_SCAN = 4'd2;
	localparam logic [3:0] S_DIV  = 4'd3;
	localparam logic [3:0] S_WDIV = 4'd4;
	localparam logic [3:0] S_SQ   = 4'd5;
	localparam logic [3:0] S_EASE = 4'd6;
	localparam logic [3:0] S_MUL  = 4'd7;
	localparam logic [3:0] S_ADD  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0]  state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] pos_q;
	key_t        in_q;
	key_t        keys [MAX_KEYS];
	logic [MAX_KEYS-1:0] sh, ld;
	key_t        lo_q, hi_q;
	logic [16:0] f_q, e_q;
	logic [32:0] sq_q;
	logic [2:0]  mode_q;
	logic [1:0]  comp_q;
	logic signed [50:0] p_q;
	logic signed [31:0] rx_q, ry_q, rz_q;
	logic signed [31:0] ox_q, oy_q, oz_q;
	logic [1:0]  st_q;
	logic [1:0]  ost_q;
	logic        ov_q;
	logic        out_load;
	logic        dstart;
	logic        ddone;
	logic [16:0] dquo;
	logic signed [32:0] num, den;

	genvar g;
	generate
		for (g = 0; g < MAX_KEYS; g++) begin : g_cell
			kce_cell u_cell (
				.clk(clk), .shift(sh[g]), .load(ld[g]), .new_key(in_q),
				.prev_key(g == 0 ? in_q : keys[(g == 0) ? 0 : g - 1]), .key(keys[g])
			);
		end
	endgenerate

	// insert: pos_q walks downward; keys[pos-1] greater -> shift into pos
	logic ins_move;
	assign ins_move = pos_q != '0 && $signed(keys[pos_q - 1'b1].t) > $signed(in_q.t);
	always_comb begin
		sh = '0;
		ld = '0;
		if (state_q == S_INS) begin
			if (ins_move) sh[pos_q] = 1'b1;
			else ld[pos_q] = 1'b1;
		end
	end

	key_t kcur, knext, klast;
	assign kcur = keys[pos_q];
	assign knext = keys[(pos_q == IW'(MAX_KEYS - 1)) ? pos_q : pos_q + 1'b1];
	assign klast = keys[IW'(count_q - 1'b1)];

	logic scan_first, scan_last;
	assign scan_first = pos_q == '0 && $signed(in_q.t) <= $signed(kcur.t);
	assign scan_last = $signed(in_q.t) >= $signed(klast.t);

	assign num = 33'(signed'(in_q.t)) - 33'(signed'(lo_q.t));
	assign den = 33'(signed'(hi_q.t)) - 33'(signed'(lo_q.t));
	assign dstart = state_q == S_DIV;

	kce_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(num), .den(den),
		.done(ddone), .quo(dquo)
	);

	logic [16:0] base;
	assign base = ease_base(f_q, mode_q);
	logic signed [32:0] diff;
	logic signed [31:0] av, bv;
	always_comb begin
		unique case (comp_q)
			2'd0: begin av = lo_q.x; bv = hi_q.x; end
			2'd1: begin av = lo_q.y; bv = hi_q.y; end
			default: begin av = lo_q.z; bv = hi_q.z; end
		endcase
	end
	assign diff = 33'(bv) - 33'(av);
	logic signed [33:0] sum;
	assign sum = 34'(av) + 34'(p_q >>> 16);
	logic signed [31:0] sat;
	assign sat = (sum > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF :
		(sum < -34'sh80000000) ? -32'sh80000000 : sum[31:0];

	assign in_stall = state_q != S_IDLE;
	assign out_load = state_q == S_OUT && (!ov_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (out_load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && !in_stall) begin
					if (command) begin
						state_q <= (count_q == '0) ? S_OUT : S_SCAN;
					end else if (count_q == CW'(MAX_KEYS)) state_q <= S_OUT;
					else state_q <= S_INS;
				end
				S_INS: if (!ins_move) begin
					count_q <= count_q + 1'b1;
					state_q <= S_OUT;
				end
				S_SCAN: begin
					if (scan_first || scan_last) state_q <= S_OUT;
					else if ($signed(in_q.t) <= $signed(knext.t)) state_q <= S_DIV;
				end
				S_DIV: state_q <= S_WDIV;
				S_WDIV: if (ddone) state_q <= S_SQ;
				S_SQ: state_q <= S_EASE;
				S_EASE: state_q <= S_MUL;
				S_MUL: state_q <= S_ADD;
				S_ADD: state_q <= (comp_q == 2'd2) ? S_OUT : S_MUL;
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				in_q <= '{t: sample_time, x: key_x, y: key_y, z: key_z, ease: ease_mode};
				pos_q <= command ? '0 : count_q[IW-1:0];
				comp_q <= 2'd0;
				rx_q <= '0; ry_q <= '0; rz_q <= '0;
				st_q <= command ? ST_EMPTY : (count_q == CW'(MAX_KEYS) ? ST_FULL : ST_STORED);
			end
			S_INS: begin
				st_q <= ST_STORED;
				if (ins_move) pos_q <= pos_q - 1'b1;
			end
			S_SCAN: begin
				st_q <= ST_EVAL;
				if (scan_first) begin
					rx_q <= kcur.x; ry_q <= kcur.y; rz_q <= kcur.z;
				end else if (scan_last) begin
					rx_q <= klast.x; ry_q <= klast.y; rz_q <= klast.z;
				end else begin
					lo_q <= kcur;
					hi_q <= knext;
					mode_q <= kcur.ease;
					pos_q <= pos_q + 1'b1;
				end
			end
			S_WDIV: if (ddone) f_q <= (den == '0) ? '0 : (dquo > ONE_Q16 ? ONE_Q16 : dquo);
			S_SQ: sq_q <= 33'(base) * 33'(base);
			S_EASE: begin
				unique case (mode_q)
					EASE_STEP: e_q <= '0;
					EASE_IN: e_q <= sq_q[32:16];
					EASE_OUT: e_q <= ONE_Q16 - sq_q[32:16];
					EASE_INOUT: e_q <= (f_q < 17'h08000) ? sq_q[31:15] :
						ONE_Q16 - sq_q[31:15];
					default: e_q <= f_q;
				endcase
			end
			S_MUL: p_q <= 51'(diff) * 51'(signed'({1'b0, e_q}));
			S_ADD: begin
				unique case (comp_q)
					2'd0: rx_q <= sat;
					2'd1: ry_q <= sat;
					default: rz_q <= sat;
				endcase
				comp_q <= comp_q + 2'd1;
			end
			S_OUT: if (out_load) begin
				ox_q <= rx_q;
				oy_q <= ry_q;
				oz_q <= rz_q;
				ost_q <= st_q;
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign out_x = ox_q;
	assign out_y = oy_q;
	assign out_z = oz_q;
	assign status = ost_q;

	`KCE_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(MAX_KEYS))
	`KCE_ASSERT_IMP(a_stall_busy, clk, arst_n, state_q != S_IDLE, in_stall)
	`KCE_ASSERT_NXT(a_ins_grow, clk, arst_n, state_q == S_INS && !ins_move,
		count_q == $past(count_q) + 1'b1)
	`KCE_ASSERT_NXT(a_out_hold, clk, arst_n, ov_q && out_stall, ov_q && $stable(ox_q))
endmodule
`default_nettype wire

// ===== rtl/core/kce_cell.sv =====
// One table cell: holds a key and shifts toward higher indexes during insert.
// Depends on kce_pkg.
`default_nettype none
module kce_cell (
	input  wire logic          clk,
	input  wire logic          shift,
	input  wire logic          load,
	input  wire kce_pkg::key_t new_key,
	input  wire kce_pkg::key_t prev_key,
	output kce_pkg::key_t      key
);
	import kce_pkg::*;
	key_t key_q;
	always_ff @(posedge clk) begin
		if (load) key_q <= new_key;
		else if (shift) key_q <= prev_key;
	end
	assign key = key_q;
endmodule
`default_nettype wire

// ===== rtl/core/kce_div.sv =====
// Restoring divider for the segment fraction, one quotient bit per cycle.
// Gives floor(num * 65536 / den) for 0 <= num <= den; no package dependencies.
`default_nettype none
module kce_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] num,
	input  wire logic [32:0] den,
	output logic             done,
	output logic [16:0]      quo
);
	logic [33:0] rem_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] den_q;
	logic [34:0] trial;
	logic [33:0] rem_sub;
	assign trial = {rem_q, 1'b0};
	assign rem_sub = trial[33:0] - {den_q, 1'b0};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd17;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) busy_q <= 1'b0;
		end
	end
	// compare against twice the divisor: remainder stays below 2*den
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q, 1'b0}) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= trial[33:0];
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= busy_q && cnt_q == 5'd1;
	end
	assign done = done_q;
	assign quo = quo_q;
endmodule
`default_nettype wire
